// ----- hw/rtl/length_prefixed_frame_deframer_defines.svh -----
// Assertion macros for the length-prefixed frame deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define LPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpfd: implication check failed");
// next-cycle implication, disabled in reset
`define LPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpfd: next-cycle check failed");
`else
`define LPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/lpfd_pkg.sv -----
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

  // header bytes, minimum lengths and reset maximum length
  localparam logic [7:0]  HDR_SHORT      = 8'hC1;
  localparam logic [7:0]  HDR_LONG       = 8'hC2;
  localparam logic [15:0] MIN_SHORT_LEN  = 16'd3;
  localparam logic [15:0] MIN_LONG_LEN   = 16'd4;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd8192;

  // result status codes
  localparam logic [2:0] ST_FRAME   = 3'd0;
  localparam logic [2:0] ST_HDR_ERR = 3'd1;
  localparam logic [2:0] ST_LEN_ERR = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_PENDING = 3'd4;

  // one received item
  typedef struct packed {
    logic [7:0] connection_id;
    logic       new_connection;
    logic [7:0] rx_byte;
  } lpfd_in_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_source;
    logic [15:0] frame_length;
    logic [7:0]  frame_code;
    logic        frame_last;
    logic        frame_start;
    logic [7:0]  data_byte;
  } lpfd_res_t;

endpackage

// ----- hw/rtl/lpfd_parser.sv -----
// Frame parser: parse state, maximum length register and per-item result logic.
module lpfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 item_valid_i,
  input  lpfd_pkg::lpfd_in_t   item_i,
  output lpfd_pkg::lpfd_res_t  res_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [15:0] max_len_q;
  logic [1:0]  phase_q, phase_d;
  logic        long_q, long_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        err_q, err_d;

  // state as seen after a new connection has restarted parsing
  logic [1:0]  phase_e;
  logic        long_e;
  logic [15:0] len_e;
  logic [15:0] seen_e;
  logic [7:0]  cmd_e;
  logic        err_e;

  logic [7:0]  b;
  logic [15:0] len_lo;
  logic [15:0] min_len;
  logic [15:0] seen_inc;
  logic [15:0] cmd_pos;
  logic        is_cmd;
  logic [7:0]  cmd_upd;

  assign b        = item_i.rx_byte;
  assign phase_e  = item_i.new_connection ? PH_HEADER : phase_q;
  assign long_e   = item_i.new_connection ? 1'b0 : long_q;
  assign len_e    = item_i.new_connection ? 16'd0 : len_q;
  assign seen_e   = item_i.new_connection ? 16'd0 : seen_q;
  assign cmd_e    = item_i.new_connection ? 8'd0 : cmd_q;
  assign err_e    = item_i.new_connection ? 1'b0 : err_q;

  assign len_lo   = long_e ? {len_e[15:8], b} : {8'd0, b};
  assign min_len  = long_e ? lpfd_pkg::MIN_LONG_LEN : lpfd_pkg::MIN_SHORT_LEN;
  assign seen_inc = seen_e + 16'd1;
  assign cmd_pos  = long_e ? lpfd_pkg::MIN_LONG_LEN : lpfd_pkg::MIN_SHORT_LEN;
  assign is_cmd   = (seen_inc == cmd_pos);
  assign cmd_upd  = is_cmd ? b : cmd_e;

  // phase update and result for one item
  always_comb begin
    phase_d = phase_e;
    long_d  = long_e;
    len_d   = len_e;
    seen_d  = seen_e;
    cmd_d   = cmd_e;
    err_d   = err_e;

    res_o              = '0;
    res_o.data_byte    = b;
    res_o.frame_source = item_i.connection_id;
    res_o.status       = lpfd_pkg::ST_FRAME;

    if (err_e) begin
      res_o.status = lpfd_pkg::ST_DROPPED;
    end else begin
      unique case (phase_e)
        PH_HEADER: begin
          if (b == lpfd_pkg::HDR_SHORT || b == lpfd_pkg::HDR_LONG) begin
            long_d            = (b == lpfd_pkg::HDR_LONG);
            phase_d           = (b == lpfd_pkg::HDR_LONG) ? PH_LEN_HI : PH_LEN_LO;
            len_d             = 16'd0;
            seen_d            = 16'd1;
            cmd_d             = 8'd0;
            res_o.frame_start = 1'b1;
            res_o.status      = lpfd_pkg::ST_PENDING;
          end else begin
            res_o.status = lpfd_pkg::ST_HDR_ERR;
            err_d        = 1'b1;
            phase_d      = PH_HEADER;
            long_d       = 1'b0;
            len_d        = 16'd0;
            seen_d       = 16'd0;
            cmd_d        = 8'd0;
          end
        end
        PH_LEN_HI: begin
          len_d        = {b, 8'd0};
          seen_d       = 16'd2;
          phase_d      = PH_LEN_LO;
          res_o.status = lpfd_pkg::ST_PENDING;
        end
        PH_LEN_LO: begin
          if (len_lo < min_len || len_lo > max_len_q) begin
            // length out of range: latch error and restart
            res_o.status = lpfd_pkg::ST_LEN_ERR;
            err_d        = 1'b1;
            phase_d      = PH_HEADER;
            long_d       = 1'b0;
            len_d        = 16'd0;
            seen_d       = 16'd0;
            cmd_d        = 8'd0;
          end else begin
            len_d   = len_lo;
            seen_d  = seen_inc;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          seen_d = seen_inc;
          cmd_d  = cmd_upd;
          if (seen_inc >= len_e) begin
            // final byte of the frame
            res_o.frame_last   = 1'b1;
            res_o.frame_code   = cmd_upd;
            res_o.frame_length = len_e;
            phase_d            = PH_HEADER;
            long_d             = 1'b0;
            len_d              = 16'd0;
            seen_d             = 16'd0;
            cmd_d              = 8'd0;
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  // parse state, updated on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      long_q  <= 1'b0;
      len_q   <= 16'd0;
      seen_q  <= 16'd0;
      cmd_q   <= 8'd0;
      err_q   <= 1'b0;
    end else if (item_valid_i) begin
      phase_q <= phase_d;
      long_q  <= long_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
    end
  end

  // maximum frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpfd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- hw/rtl/lpfd_out_reg.sv -----
// Result register between the parser and the output stream.
module lpfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  lpfd_pkg::lpfd_res_t  res_i,
  input  logic                 out_ready_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  output lpfd_pkg::lpfd_res_t  res_o
);

  logic                valid_q, valid_d;
  lpfd_pkg::lpfd_res_t res_q;

  // free when empty or being drained this cycle
  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/length_prefixed_frame_deframer.sv -----
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; parse state updates on acceptance.
// s_axis_tready is low only while the output register holds a result not yet taken.
// Reset (asynchronous, active low): parser back to header phase, error cleared,
// maximum frame length 8192, output register empty.
`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], connection_id[15:8]
  input  logic [0:0]  s_axis_tuser,   // new_connection[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_byte[7:0], frame_code[15:8],
                                      // frame_length[31:16], frame_source[39:32]
  output logic [3:0]  m_axis_tuser,   // frame_start[0], status[3:1]
  output logic        m_axis_tlast
);

  lpfd_pkg::lpfd_in_t  item;
  lpfd_pkg::lpfd_res_t res_comb;
  lpfd_pkg::lpfd_res_t res_out;
  logic                can_load;
  logic                accept;

  // unpack the input item
  assign item.rx_byte        = s_axis_tdata[7:0];
  assign item.connection_id  = s_axis_tdata[15:8];
  assign item.new_connection = s_axis_tuser[0];

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && can_load;

  lpfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (accept),
    .item_i       (item),
    .res_o        (res_comb)
  );

  lpfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_comb),
    .out_ready_i (m_axis_tready),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid),
    .res_o       (res_out)
  );

  // pack the result item
  assign m_axis_tdata = {res_out.frame_source, res_out.frame_length,
                         res_out.frame_code, res_out.data_byte};
  assign m_axis_tuser = {res_out.status, res_out.frame_start};
  assign m_axis_tlast = res_out.frame_last;

  // checks
  `LPFD_ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni, accept, m_axis_tvalid)
  `LPFD_ASSERT_IMP(a_last_is_frame_byte, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[3:1] == lpfd_pkg::ST_FRAME)
  `LPFD_ASSERT_IMP(a_start_is_pending, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:1] == lpfd_pkg::ST_PENDING)
  `LPFD_ASSERT_IMP(a_summary_only_on_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[31:8] == 24'd0)

endmodule
